// ===== rtl/lprt_pkg.sv =====
// ----------------------------------------------------------------------------
// lprt_pkg
// Types, codes and controller commands shared by the key table modules.
// ----------------------------------------------------------------------------
package lprt_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned LOC_W  = 32;
  localparam int unsigned COP_W  = 8;

  typedef enum logic [2:0] {
    CMD_PUBLISH   = 3'd0,
    CMD_ACQUIRE   = 3'd1,
    CMD_RELEASE   = 3'd2,
    CMD_LOOKUP    = 3'd3,
    CMD_EVICTABLE = 3'd4,
    CMD_RESERVE   = 3'd5,
    CMD_RSVD6     = 3'd6,
    CMD_RSVD7     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_NOSPACE  = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  localparam logic ADDR_LAYOUT = 1'b0;
  localparam logic ADDR_ALIVE  = 1'b1;

  typedef struct packed {
    logic [2:0]       command;
    logic [KEY_W-1:0] key;
    logic [COP_W-1:0] copies;
    logic [LOC_W-1:0] location_in;
    logic [LOC_W-1:0] request_layout;
    logic             last_key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LOC_W-1:0] location_out;
    logic             answer;
    logic             changed;
    logic             last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,    // clear valid map after reset
    S_IDLE,
    S_RD,       // issue read at probe pointer
    S_WAIT,     // memory read latency
    S_CHK,      // inspect probe slot
    S_DRD,      // delete: read next slot
    S_DWAIT,
    S_DCHK,     // delete: decide shift
    S_DONE,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;    // clear valid at pointer, advance
    logic load;        // capture input word, pointer to home
    logic rd;          // read slot at pointer
    logic probe_next;  // advance probe pointer
    logic do_hit;      // apply command to hit slot
    logic do_miss;     // apply command on miss (insert/no_space)
    logic del_start;   // hole = pointer, nx = pointer+1
    logic drd;         // read slot nx
    logic dshift;      // copy nx into hole, hole = nx
    logic dadv;        // nx = nx+1
    logic dend;        // invalidate hole
    logic finish;      // build result word
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_publish;
    logic cmd_walk;     // command needs a probe
    logic early;        // answered without probe
    logic slot_vld;
    logic key_eq;
    logic wrapped;      // probe visited all slots
    logic need_del;     // hit publish with copies zero
    logic d_vld;
    logic d_move;
    logic d_wrap;
  } sts_t;

endpackage

// ===== rtl/linear_probe_reader_table_top.sv =====
// Flow: an accepted word reads, waits on and checks each probed slot in turn, then
// each slot scanned by a delete shift; a word answered without a probe skips both.
// One word at a time: the next word is taken only after the result is accepted.
// Reset: synchronous active low; a clearing pass over every slot wipes
// the valid map, during which no input word is taken.
// ----------------------------------------------------------------------------
// linear_probe_reader_table_top
// Linear probing key table with reader counts and backward-shift delete.
// ----------------------------------------------------------------------------
module linear_probe_reader_table_top #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned READER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lprt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lprt_pkg::out_word_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import lprt_pkg::*;

  logic [31:0] layout_r;
  logic        alive_r;
  ctl_t        ctl;
  sts_t        sts;

  assign cfg_pready = 1'b1;
  wire wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= '0;
      alive_r  <= 1'b1;
    end else if (wr) begin
      if (cfg_paddr[2] == ADDR_LAYOUT) layout_r <= cfg_pwdata;
      else alive_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ADDR_ALIVE) ? {31'd0, alive_r} : layout_r;

  lprt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .ctl
  );

  lprt_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS), .READER_BITS(READER_BITS)
  ) u_dpath (
    .clk, .rst_n, .in_data, .out_data, .layout(layout_r), .alive(alive_r), .ctl, .sts
  );

endmodule

// ===== rtl/lprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lprt_ctrl
// Sequencer for probe, update and backward-shift delete.
// ----------------------------------------------------------------------------
module lprt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  lprt_pkg::sts_t  sts,
  output lprt_pkg::ctl_t  ctl
);
  import lprt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_RD;
      S_RD:    state_nxt = sts.early ? S_DONE : S_WAIT;
      S_WAIT:  state_nxt = S_CHK;
      S_CHK: begin
        if (!sts.slot_vld) state_nxt = S_DONE;
        else if (sts.key_eq) state_nxt = sts.need_del ? S_DRD : S_DONE;
        else if (sts.wrapped) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_DRD:   state_nxt = sts.d_wrap ? S_DONE : S_DWAIT;
      S_DWAIT: state_nxt = S_DCHK;
      S_DCHK:  state_nxt = sts.d_vld ? S_DRD : S_DONE;
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: ctl.clr_step = 1'b1;
      S_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      S_RD:    ctl.rd = 1'b1;
      S_WAIT:  ;
      S_CHK: begin
        if (!sts.slot_vld || (!sts.key_eq && sts.wrapped)) ctl.do_miss = 1'b1;
        else if (sts.key_eq) begin
          ctl.do_hit    = 1'b1;
          ctl.del_start = sts.need_del;
        end else ctl.probe_next = 1'b1;
      end
      S_DRD: begin
        ctl.drd  = !sts.d_wrap;
        ctl.dend = sts.d_wrap;
      end
      S_DWAIT: ;
      S_DCHK: begin
        if (!sts.d_vld) ctl.dend = 1'b1;
        else begin
          ctl.dshift = sts.d_move;
          ctl.dadv   = 1'b1;
        end
      end
      S_DONE: ctl.finish = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/lprt_dpath.sv =====
// ----------------------------------------------------------------------------
// lprt_dpath
// Slot memories, valid map, probe pointers and result register.
// ----------------------------------------------------------------------------
module lprt_dpath #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned READER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lprt_pkg::in_word_t  in_data,
  output lprt_pkg::out_word_t out_data,
  input  logic [31:0]         layout,
  input  logic                alive,
  input  lprt_pkg::ctl_t      ctl,
  output lprt_pkg::sts_t      sts
);
  import lprt_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
  localparam logic [READER_BITS-1:0] RMAX = '1;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [COP_W-1:0]       cop;
    logic [LOC_W-1:0]       loc;
    logic [READER_BITS-1:0] rdr;
    logic                   busy;
  } slot_t;

  slot_t         mem [TABLE_DEPTH];
  logic          vld_mem [TABLE_DEPTH];
  slot_t         rd_r;
  logic          rv_r;
  slot_t         wd;
  logic [AW-1:0] wa;
  logic          we;
  logic          vwe, vwd;
  logic [AW-1:0] vwa;

  logic [2:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [COP_W-1:0]    cop_r;
  logic [LOC_W-1:0]    loc_r;
  logic                mism_r, lst_r;
  logic [AW-1:0]       ptr_r, hole_r, nx_r, ra;
  logic [CW-1:0]       cnt_r;
  logic [1:0]          st_r;
  logic [LOC_W-1:0]    lo_r;
  logic                ans_r, chg_r;
  out_word_t           out_r;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // fold the low key bits into the slot range
  function automatic logic [AW-1:0] home(input logic [KEY_BITS-1:0] k);
    logic [CW-1:0] h;
    h = {1'b0, k[AW-1:0]};
    if (h >= CW'(TABLE_DEPTH)) h = h - CW'(TABLE_DEPTH);
    return h[AW-1:0];
  endfunction

  // cyclic distance from home to p
  function automatic logic [AW-1:0] cyc_dist(input logic [AW-1:0] p, input logic [AW-1:0] h);
    logic [CW-1:0] s;
    s = {1'b0, p} - {1'b0, h};
    if (p < h) s = s + CW'(TABLE_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [KEY_BITS-1:0] key_in;
  assign key_in = in_data.key[KEY_BITS-1:0];
  assign ra     = ctl.drd ? nx_r : ptr_r;

  always_ff @(posedge clk) begin
    if (ctl.rd || ctl.drd) begin
      rd_r <= mem[ra];
      rv_r <= vld_mem[ra];
    end
    if (we) mem[wa] <= wd;
    if (vwe) vld_mem[vwa] <= vwd;
  end

  wire cmd_t cmd = cmd_t'(cmd_r);
  wire hit_ok = (rd_r.cop != '0) && !rd_r.busy;
  wire evict  = (rd_r.rdr == '0) && !rd_r.busy;

  always_comb begin
    we = 1'b0;
    wa = ptr_r;
    wd = rd_r;
    if (ctl.do_hit) begin
      unique case (cmd)
        CMD_PUBLISH: begin
          we = 1'b1; wd.cop = cop_r; wd.loc = loc_r; wd.busy = 1'b0;
        end
        CMD_ACQUIRE: begin
          we = hit_ok; if (rd_r.rdr != RMAX) wd.rdr = rd_r.rdr + 1'b1;
        end
        CMD_RELEASE: begin
          we = rd_r.rdr != '0; wd.rdr = rd_r.rdr - 1'b1;
        end
        CMD_RESERVE: begin
          we = evict; wd.busy = 1'b1;
        end
        default: ;
      endcase
    end else if (ctl.do_miss && cmd == CMD_PUBLISH && rv_r == 1'b0 && cop_r != '0) begin
      we = 1'b1;
      wd = '{key: key_r, cop: cop_r, loc: loc_r, rdr: '0, busy: 1'b0};
    end else if (ctl.dshift) begin
      we = 1'b1; wa = hole_r; wd = rd_r;
    end
  end

  // valid map write port: clearing pass, insert, end of delete
  always_comb begin
    vwe = 1'b0;
    vwa = ptr_r;
    vwd = 1'b0;
    priority if (ctl.clr_step) begin
      vwe = 1'b1;
    end else if (we && ctl.do_miss) begin
      vwe = 1'b1;
      vwd = 1'b1;
    end else if (ctl.dend) begin
      vwe = 1'b1;
      vwa = hole_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      if (ctl.clr_step) begin
        ptr_r <= inc(ptr_r);
      end
      if (ctl.load) ptr_r <= home(key_in);
      if (ctl.probe_next) ptr_r <= inc(ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_data.command;
      key_r  <= key_in;
      cop_r  <= in_data.copies;
      loc_r  <= in_data.location_in;
      lst_r  <= in_data.last_key;
      mism_r <= in_data.request_layout != layout;
      cnt_r  <= '0;
      st_r   <= ST_OK; lo_r <= '0; ans_r <= 1'b0; chg_r <= 1'b0;
    end
    if (ctl.probe_next) cnt_r <= cnt_r + 1'b1;
    if (ctl.do_hit) begin
      unique case (cmd)
        CMD_PUBLISH: chg_r <= (rd_r.cop != cop_r) || (rd_r.loc != loc_r) || rd_r.busy;
        CMD_ACQUIRE: begin
          if (hit_ok) lo_r <= rd_r.loc; else st_r <= ST_NOTFOUND;
        end
        CMD_LOOKUP:  ans_r <= hit_ok;
        CMD_EVICTABLE, CMD_RESERVE: ans_r <= evict;
        default: ;
      endcase
    end
    if (ctl.do_miss) begin
      if (cmd == CMD_ACQUIRE) st_r <= ST_NOTFOUND;
      if (cmd == CMD_PUBLISH && cop_r != '0) begin
        if (rv_r) st_r <= ST_NOSPACE; else chg_r <= 1'b1;
      end
    end
    if (ctl.rd && sts.early) begin
      if (cmd == CMD_ACQUIRE) st_r <= mism_r ? ST_MISMATCH : ST_NOTFOUND;
    end
    if (ctl.del_start) begin
      hole_r <= ptr_r;
      nx_r   <= inc(ptr_r);
    end
    if (ctl.dshift) hole_r <= nx_r;
    if (ctl.dadv) nx_r <= inc(nx_r);
    if (ctl.finish) out_r <= '{status: st_r, location_out: lo_r, answer: ans_r,
                               changed: chg_r, last: lst_r};
  end

  wire [AW-1:0] hm = home(rd_r.key);

  always_comb begin
    sts            = '0;
    sts.clr_last   = ptr_r == LAST_IDX;
    sts.is_publish = cmd == CMD_PUBLISH;
    sts.early      = (cmd == CMD_RSVD6) || (cmd == CMD_RSVD7) ||
                     (cmd == CMD_ACQUIRE && (mism_r || !alive)) ||
                     (cmd == CMD_LOOKUP && !alive);
    sts.cmd_walk   = !sts.early;
    sts.slot_vld   = rv_r;
    sts.key_eq     = rd_r.key == key_r;
    sts.wrapped    = cnt_r == CW'(TABLE_DEPTH - 1);
    sts.need_del   = (cmd == CMD_PUBLISH) && (cop_r == '0);
    sts.d_vld      = rv_r;
    sts.d_move     = cyc_dist(hole_r, hm) < cyc_dist(nx_r, hm);
    // stop when the scan comes back to the deleted slot
    sts.d_wrap     = nx_r == ptr_r;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/lprt_checker.sv =====
// ----------------------------------------------------------------------------
// lprt_checker
// Port-level checks on the key table handshakes and result codes.
// ----------------------------------------------------------------------------
module lprt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lprt_pkg::out_word_t out_data,
  input logic                cfg_pready
);
  import lprt_pkg::*;

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // one word in flight: no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken with result pending");

  // no location on a request that fails
  a_loc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.location_out == '0)
    else $error("location on failed request");

  a_rdy: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind linear_probe_reader_table_top lprt_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data, .cfg_pready
);
